@@ rtl/rdc_pkg.sv @@
// Shared definitions for the radix digit converter: widths, limits, the
// sequencer state type and the tally split of a digit.
// No dependencies.
`timescale 1ns / 1ps

package rdc_pkg;

    localparam int VALUE_WIDTH = 31;
    localparam int MAX_DIGITS  = 31;

    localparam int BASE_W  = 5;
    localparam int DIGIT_W = 5;
    localparam int DOTS_W  = 3;
    localparam int BARS_W  = 2;

    // Digit counter holds MAX_DIGITS itself; the store index only the entries.
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W  = $clog2(MAX_DIGITS);
    localparam int ITER_W = $clog2(VALUE_WIDTH + 1);

    localparam logic [BASE_W-1:0]  BASE_MIN = BASE_W'(2);
    localparam logic [BASE_W-1:0]  BASE_MAX = BASE_W'(20);
    localparam logic [DIGIT_W-1:0] TALLY    = DIGIT_W'(5);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_READ,
        S_OUT,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic [DOTS_W-1:0] dots;
        logic [BARS_W-1:0] bars;
    } t_tally;

    // Bars are the digit divided by five, dots the remainder. Digits stay
    // below twenty, so three compares settle the quotient.
    function automatic t_tally tally_split(input logic [DIGIT_W-1:0] digit);
        t_tally               res;
        logic [DIGIT_W-1:0]   rest;
        res  = '0;
        rest = digit;
        if (digit >= DIGIT_W'(3) * TALLY) begin
            res.bars = BARS_W'(3);
            rest     = digit - DIGIT_W'(3) * TALLY;
        end else if (digit >= DIGIT_W'(2) * TALLY) begin
            res.bars = BARS_W'(2);
            rest     = digit - DIGIT_W'(2) * TALLY;
        end else if (digit >= TALLY) begin
            res.bars = BARS_W'(1);
            rest     = digit - TALLY;
        end
        res.dots = rest[DOTS_W-1:0];
        return res;
    endfunction

endpackage

@@ rtl/rdc_ram.sv @@
// Generic single-write, single-read memory with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/rdc_divider.sv @@
// Bit-serial restoring divider: one quotient bit per cycle of a wide
// dividend by a small divisor. Depends on rdc_pkg.
`timescale 1ns / 1ps

module rdc_divider (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [rdc_pkg::VALUE_WIDTH-1:0] i_dividend,
    input  logic [rdc_pkg::BASE_W-1:0]      i_divisor,
    output logic                            o_done,
    output logic [rdc_pkg::VALUE_WIDTH-1:0] o_quotient,
    output logic [rdc_pkg::BASE_W-1:0]      o_remainder
);

    logic [rdc_pkg::VALUE_WIDTH-1:0] r_q, n_q;
    logic [rdc_pkg::BASE_W-1:0]      r_rem, n_rem;
    logic [rdc_pkg::BASE_W-1:0]      r_div, n_div;
    logic [rdc_pkg::ITER_W-1:0]      r_iter, n_iter;
    logic                            r_busy, n_busy;
    logic                            r_done, n_done;

    logic [rdc_pkg::BASE_W:0] rem_shift;
    logic [rdc_pkg::BASE_W:0] rem_diff;
    logic                     fits;

    // The partial remainder stays below the divisor, so one subtract of the
    // shifted remainder decides each quotient bit.
    assign rem_shift = {r_rem, r_q[rdc_pkg::VALUE_WIDTH-1]};
    assign fits      = rem_shift >= {1'b0, r_div};
    assign rem_diff  = rem_shift - {1'b0, r_div};

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_div  = r_div;
        n_iter = r_iter;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_q    = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
            n_iter = rdc_pkg::ITER_W'(rdc_pkg::VALUE_WIDTH);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_q    = {r_q[rdc_pkg::VALUE_WIDTH-2:0], fits};
            n_rem  = fits ? rem_diff[rdc_pkg::BASE_W-1:0] : rem_shift[rdc_pkg::BASE_W-1:0];
            n_iter = r_iter - rdc_pkg::ITER_W'(1);
            if (r_iter == rdc_pkg::ITER_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_iter <= n_iter;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;

endmodule

@@ rtl/radix_digit_converter_core.sv @@
// Top level of the radix digit converter: sequencer, digit store and
// output register. Depends on rdc_pkg, rdc_divider and rdc_ram.
`timescale 1ns / 1ps
//
// Channel   Signals                                           Direction
// input     i_in_valid, o_in_ready, i_value, i_base           into block
// output    o_out_valid, i_out_ready, o_digit, o_dots,        out of block
//           o_bars, o_last
//
// Each digit passes through the shared bit-serial divider: a load, one
// quotient bit per cycle, then the done strobe.
// Emitting each digit then takes a registered read of the digit store,
// the load of the output register and the transfer itself, which waits
// for the consumer.
// Reset is synchronous and active low; it returns the sequencer to idle and
// drops the output valid. The digit store needs no clearing.
// The block takes one item at a time: input ready is high only while idle,
// and a stalled output simply holds the current digit.

module radix_digit_converter_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [rdc_pkg::VALUE_WIDTH-1:0] i_value,
    input  logic [rdc_pkg::BASE_W-1:0]      i_base,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [rdc_pkg::DIGIT_W-1:0]     o_digit,
    output logic [rdc_pkg::DOTS_W-1:0]      o_dots,
    output logic [rdc_pkg::BARS_W-1:0]      o_bars,
    output logic                            o_last
);

    rdc_pkg::t_state r_state, n_state;

    // Running quotient and the clamped base of the item in progress.
    logic [rdc_pkg::VALUE_WIDTH-1:0] r_quot, n_quot;
    logic [rdc_pkg::BASE_W-1:0]      r_base, n_base;

    // Number of digits stored so far, and the store index being emitted.
    logic [rdc_pkg::CNT_W-1:0] r_count, n_count;
    logic [rdc_pkg::IDX_W-1:0] r_idx, n_idx;

    // Output register.
    logic                        r_out_valid, n_out_valid;
    logic [rdc_pkg::DIGIT_W-1:0] r_digit, n_digit;
    logic [rdc_pkg::DOTS_W-1:0]  r_dots, n_dots;
    logic [rdc_pkg::BARS_W-1:0]  r_bars, n_bars;
    logic                        r_last, n_last;

    logic                            div_start;
    logic                            div_done;
    logic [rdc_pkg::VALUE_WIDTH-1:0] div_quot;
    logic [rdc_pkg::BASE_W-1:0]      div_rem;

    logic                        ram_we;
    logic                        ram_re;
    logic [rdc_pkg::DIGIT_W-1:0] ram_rdata;

    logic [rdc_pkg::BASE_W-1:0] base_clamped;
    logic [rdc_pkg::CNT_W-1:0]  count_inc;
    rdc_pkg::t_tally            split;

    logic in_xfer;
    logic out_xfer;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = r_out_valid && i_out_ready;

    // Bases outside 2..20 are pulled to the nearest end of the range.
    always_comb begin
        priority if (i_base < rdc_pkg::BASE_MIN) begin
            base_clamped = rdc_pkg::BASE_MIN;
        end else if (i_base > rdc_pkg::BASE_MAX) begin
            base_clamped = rdc_pkg::BASE_MAX;
        end else begin
            base_clamped = i_base;
        end
    end

    assign count_inc = r_count + rdc_pkg::CNT_W'(1);
    assign split     = rdc_pkg::tally_split(ram_rdata);

    rdc_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_quot),
        .i_divisor   (r_base),
        .o_done      (div_done),
        .o_quotient  (div_quot),
        .o_remainder (div_rem)
    );

    // Remainders are written least significant first at the running count
    // and read back from the last one written down to entry zero.
    rdc_ram #(
        .WIDTH (rdc_pkg::DIGIT_W),
        .DEPTH (rdc_pkg::MAX_DIGITS)
    ) u_digit_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[rdc_pkg::IDX_W-1:0]),
        .i_wdata (div_rem),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_quot      = r_quot;
        n_base      = r_base;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_digit     = r_digit;
        n_dots      = r_dots;
        n_bars      = r_bars;
        n_last      = r_last;
        div_start   = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            rdc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (in_xfer) begin
                    n_quot  = i_value;
                    n_base  = base_clamped;
                    n_count = '0;
                    n_state = rdc_pkg::S_LOAD;
                end
            end
            rdc_pkg::S_LOAD: begin
                div_start = 1'b1;
                n_state   = rdc_pkg::S_DIV;
            end
            rdc_pkg::S_DIV: begin
                if (div_done) begin
                    // Store this remainder; go on while the quotient is
                    // nonzero and the store still has room.
                    ram_we  = 1'b1;
                    n_quot  = div_quot;
                    n_count = count_inc;
                    if (div_quot != '0 &&
                        count_inc < rdc_pkg::CNT_W'(rdc_pkg::MAX_DIGITS)) begin
                        n_state = rdc_pkg::S_LOAD;
                    end else begin
                        n_idx   = r_count[rdc_pkg::IDX_W-1:0];
                        n_state = rdc_pkg::S_READ;
                    end
                end
            end
            rdc_pkg::S_READ: begin
                ram_re  = 1'b1;
                n_state = rdc_pkg::S_OUT;
            end
            rdc_pkg::S_OUT: begin
                n_out_valid = 1'b1;
                n_digit     = ram_rdata;
                n_dots      = split.dots;
                n_bars      = split.bars;
                n_last      = (r_idx == '0);
                n_state     = rdc_pkg::S_HOLD;
            end
            rdc_pkg::S_HOLD: begin
                if (out_xfer) begin
                    n_out_valid = 1'b0;
                    if (r_last) begin
                        n_state = rdc_pkg::S_IDLE;
                    end else begin
                        n_idx   = r_idx - rdc_pkg::IDX_W'(1);
                        n_state = rdc_pkg::S_READ;
                    end
                end
            end
            default: begin
                n_state = rdc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rdc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_quot      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            r_quot      <= n_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base  <= n_base;
        r_idx   <= n_idx;
        r_digit <= n_digit;
        r_dots  <= n_dots;
        r_bars  <= n_bars;
        r_last  <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_digit     = r_digit;
    assign o_dots      = r_dots;
    assign o_bars      = r_bars;
    assign o_last      = r_last;

`ifndef SYNTHESIS

    // No new item is taken while a digit of the previous one is pending.
    a_no_accept_while_out: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !o_in_ready
    ) else $error("input ready while a digit is pending");

    // The divider only reports completion while the sequencer waits for it.
    a_done_in_div: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == rdc_pkg::S_DIV)
    ) else $error("divider done outside the divide state");

    // Transfer of the final digit returns the block to idle.
    a_last_to_idle: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && r_last) |=> (r_state == rdc_pkg::S_IDLE)
    ) else $error("final digit did not end the item");

    // The digit count never runs past the store.
    a_count_bound: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rdc_pkg::CNT_W'(rdc_pkg::MAX_DIGITS)
    ) else $error("digit count beyond store depth");

`endif

endmodule
